[rtl/core/skrf_pkg.sv]
package skrf_pkg;

   localparam int DEFAULT_STORE_DEPTH = 128;

   // Opcodes of one request transfer
   localparam logic [1:0] OP_SERIAL   = 2'd0;
   localparam logic [1:0] OP_SET_IDLE = 2'd1;
   localparam logic [1:0] OP_REPORT   = 2'd2;

   // Parser phases
   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_LEN     = 2'd1;
   localparam logic [1:0] PH_COLLECT = 2'd2;

   // Configuration register indexes
   localparam logic CSR_STRING_CMD = 1'b0;
   localparam logic CSR_REPORT_CMD = 1'b1;

   localparam logic [7:0] STRING_CMD_RESET = 8'd1;
   localparam logic [7:0] REPORT_CMD_RESET = 8'd2;

   // Report geometry
   localparam int REPORT_LEN = 7;   // modifier plus six keys
   localparam int KEY_COUNT  = 6;
   localparam int STRING_LEN = 2;   // modifier plus one key

   typedef struct packed {
      logic load_item;
      logic exec;
      logic pop_issue;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pop_needed;
      logic report_mode;
      logic out_free;
   } dp_status_type;

endpackage

[rtl/core/skrf_ctrl.sv]
module skrf_ctrl import skrf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_WAIT = 5'b00001,
      ST_EXEC = 5'b00010,
      ST_POP  = 5'b00100,
      ST_CAPT = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] pop_cnt_ff, pop_cnt_in;
   logic [2:0] pop_last;

   assign pop_last  = status.report_mode ? 3'(REPORT_LEN - 1) : 3'(STRING_LEN - 1);
   assign req_stall = (state_ff != ST_WAIT);

   always_comb begin
      state_in       = state_ff;
      pop_cnt_in     = pop_cnt_ff;
      cmd            = '0;
      case (state_ff)
         ST_WAIT: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec   = 1'b1;
            pop_cnt_in = '0;
            state_in   = status.pop_needed ? ST_POP : ST_DONE;
         end
         ST_POP: begin
            cmd.pop_issue = 1'b1;
            if (pop_cnt_ff == pop_last) begin
               state_in = ST_CAPT;
            end else begin
               pop_cnt_in = pop_cnt_ff + 3'd1;
            end
         end
         ST_CAPT: begin
            // last read byte lands in its slot this cycle
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_WAIT;
            end
         end
         default: begin
            state_in = ST_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_WAIT;
         pop_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pop_cnt_ff <= pop_cnt_in;
      end
   end

endmodule

[rtl/core/skrf_datapath.sv]
module skrf_datapath import skrf_pkg::*; #(
   parameter int STORE_DEPTH = DEFAULT_STORE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [1:0]    req_opcode,
   input  logic [7:0]    req_rx_byte,
   input  logic          req_usb_configured,
   input  logic          req_host_path_full,
   input  logic          csr_write_enable,
   input  logic          csr_index,
   input  logic [7:0]    csr_write_data,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic          rsp_forward_valid,
   output logic [7:0]    rsp_forward_byte,
   output logic          rsp_report_send,
   output logic [7:0]    rsp_modifier,
   output logic [8*KEY_COUNT-1:0] rsp_key_codes
);

   localparam int PTR_W   = $clog2(STORE_DEPTH);
   localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
   localparam int LEN_MAX = (STORE_DEPTH < 255) ? STORE_DEPTH : 255;
   localparam int BL_W    = $clog2(LEN_MAX + 1);

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      ptr_next = (ptr == PTR_W'(STORE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   // latched request
   logic [1:0] op_ff;
   logic [7:0] byte_ff;
   logic       cfgd_ff, full_ff;

   // configuration
   logic [7:0] str_cmd_ff, rep_cmd_ff;

   // parser and store state
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [1:0]       phase_ff, phase_in;
   logic             mode_ff, mode_in;
   logic [BL_W-1:0]  left_ff, left_in;
   logic             granted_ff, granted_in;
   logic             initial_ff, initial_in;

   // result under construction
   logic       res_fwd_ff, res_fwd_in;
   logic [7:0] res_byte_ff, res_byte_in;
   logic       res_send_ff, res_send_in;

   logic [7:0] store_mem [STORE_DEPTH];
   logic [7:0] rd_data_ff;
   logic       rd_valid_ff;
   logic [2:0] cap_idx_ff;
   logic [7:0] slot_ff [REPORT_LEN];

   logic            push;
   logic            pop_needed;
   logic [BL_W-1:0] len_cap;

   logic       rsp_valid_ff, rsp_fwd_ff, rsp_send_ff;
   logic [7:0] rsp_byte_ff, rsp_mod_ff;
   logic [8*KEY_COUNT-1:0] rsp_keys_ff;

   assign len_cap = (32'(byte_ff) > 32'(STORE_DEPTH)) ? BL_W'(STORE_DEPTH) : BL_W'(byte_ff);

   always_comb begin
      rd_ptr_in   = rd_ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      fill_in     = fill_ff;
      phase_in    = phase_ff;
      mode_in     = mode_ff;
      left_in     = left_ff;
      granted_in  = granted_ff;
      initial_in  = initial_ff;
      res_fwd_in  = res_fwd_ff;
      res_byte_in = res_byte_ff;
      res_send_in = res_send_ff;
      push        = 1'b0;
      pop_needed  = 1'b0;
      if (cmd.exec) begin
         res_fwd_in  = 1'b0;
         res_byte_in = '0;
         res_send_in = 1'b0;
         case (op_ff)
            OP_SERIAL: begin
               case (phase_ff)
                  PH_LEN: begin
                     left_in  = len_cap;
                     phase_in = (len_cap == '0) ? PH_IDLE : PH_COLLECT;
                  end
                  PH_COLLECT: begin
                     // drop the byte and keep the count when the store is full
                     if (fill_ff < CNT_W'(STORE_DEPTH)) begin
                        push = 1'b1;
                        if (left_ff != '0) begin
                           left_in = left_ff - 1'b1;
                           if (left_ff == BL_W'(1)) begin
                              phase_in = PH_IDLE;
                           end
                        end else begin
                           phase_in = PH_IDLE;
                        end
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     if (byte_ff == str_cmd_ff) begin
                        phase_in = PH_LEN;
                        mode_in  = 1'b0;
                     end else if (byte_ff == rep_cmd_ff) begin
                        left_in  = BL_W'(REPORT_LEN);
                        phase_in = PH_COLLECT;
                        mode_in  = 1'b1;
                     end else if (cfgd_ff && !full_ff) begin
                        res_fwd_in  = 1'b1;
                        res_byte_in = byte_ff;
                     end
                  end
               endcase
            end
            OP_SET_IDLE: begin
               granted_in = 1'b1;
            end
            OP_REPORT: begin
               if (granted_ff) begin
                  res_send_in = 1'b1;
                  if (!initial_ff) begin
                     initial_in = 1'b1;
                  end else if (mode_ff ? (fill_ff >= CNT_W'(REPORT_LEN))
                                       : (fill_ff >= CNT_W'(STRING_LEN))) begin
                     pop_needed = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (push) begin
         wr_ptr_in = ptr_next(wr_ptr_ff);
         fill_in   = fill_ff + 1'b1;
      end
      if (cmd.pop_issue) begin
         rd_ptr_in = ptr_next(rd_ptr_ff);
         fill_in   = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         str_cmd_ff   <= STRING_CMD_RESET;
         rep_cmd_ff   <= REPORT_CMD_RESET;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         fill_ff      <= '0;
         phase_ff     <= PH_IDLE;
         mode_ff      <= 1'b0;
         left_ff      <= '0;
         granted_ff   <= 1'b0;
         initial_ff   <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_STRING_CMD: str_cmd_ff <= csr_write_data;
               CSR_REPORT_CMD: rep_cmd_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
         rd_ptr_ff   <= rd_ptr_in;
         wr_ptr_ff   <= wr_ptr_in;
         fill_ff     <= fill_in;
         phase_ff    <= phase_in;
         mode_ff     <= mode_in;
         left_ff     <= left_in;
         granted_ff  <= granted_in;
         initial_ff  <= initial_in;
         rd_valid_ff <= cmd.pop_issue;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff   <= req_opcode;
         byte_ff <= req_rx_byte;
         cfgd_ff <= req_usb_configured;
         full_ff <= req_host_path_full;
      end
      res_fwd_ff  <= res_fwd_in;
      res_byte_ff <= res_byte_in;
      res_send_ff <= res_send_in;
      if (cmd.exec) begin
         cap_idx_ff <= '0;
         slot_ff    <= '{default: '0};
      end else if (rd_valid_ff) begin
         slot_ff[cap_idx_ff] <= rd_data_ff;
         cap_idx_ff          <= cap_idx_ff + 3'd1;
      end
      if (cmd.load_out) begin
         rsp_fwd_ff  <= res_fwd_ff;
         rsp_byte_ff <= res_byte_ff;
         rsp_send_ff <= res_send_ff;
         rsp_mod_ff  <= slot_ff[0];
         for (int k = 0; k < KEY_COUNT; k++) begin
            rsp_keys_ff[8*k +: 8] <= slot_ff[3'(k + 1)];
         end
      end
   end

   // key store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (push) begin
         store_mem[wr_ptr_ff] <= byte_ff;
      end
      if (cmd.pop_issue) begin
         rd_data_ff <= store_mem[rd_ptr_ff];
      end
   end

   assign status.pop_needed  = pop_needed;
   assign status.report_mode = mode_ff;
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_forward_valid = rsp_fwd_ff;
   assign rsp_forward_byte  = rsp_byte_ff;
   assign rsp_report_send   = rsp_send_ff;
   assign rsp_modifier      = rsp_mod_ff;
   assign rsp_key_codes     = rsp_keys_ff;

endmodule

[rtl/core/serial_to_keyboard_report_framer_core.sv]
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    opcode, rx_byte, usb_configured, host_path_full
// rsp_      out        rsp_valid/stall    forward_valid/byte, report_send, modifier, key_codes
// csr_      in         csr_write_enable   csr_index (0 string cmd, 1 report cmd), write_data
//
// One request at a time: accept, decode, pop the key store when a report needs it,
// then the result register. Reports pop through the single registered read port
// of the key store.
// Reset is synchronous and clears the control state, all but the capture index;
// store contents stay undefined.
// The result register frees the request side: the next request is taken while a
// result still stalls, and its result waits in the hand-off state until the
// register frees.
module serial_to_keyboard_report_framer_core import skrf_pkg::*; #(
   parameter int STORE_DEPTH = DEFAULT_STORE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_usb_configured,
   input  logic        req_host_path_full,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_forward_valid,
   output logic [7:0]  rsp_forward_byte,
   output logic        rsp_report_send,
   output logic [7:0]  rsp_modifier,
   output logic [8*KEY_COUNT-1:0] rsp_key_codes,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [7:0]  csr_write_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequence each transfer: latch, decode, pop, hand off
   skrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // hold parser state, key store, report slots and the result register
   skrf_datapath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_opcode         (req_opcode),
      .req_rx_byte        (req_rx_byte),
      .req_usb_configured (req_usb_configured),
      .req_host_path_full (req_host_path_full),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_forward_valid  (rsp_forward_valid),
      .rsp_forward_byte   (rsp_forward_byte),
      .rsp_report_send    (rsp_report_send),
      .rsp_modifier       (rsp_modifier),
      .rsp_key_codes      (rsp_key_codes)
   );

endmodule
